/* src/rpa_pkg.sv */
// Package for the playout admission block: event and verdict codes,
// item structs and constants. Used by every module of the block.
`default_nettype none

package rpa_pkg;

   localparam int unsigned TsWidth       = 32;
   localparam int unsigned SeqWidth      = 16;
   localparam int unsigned SizeWidth     = 11;
   localparam int unsigned AvgWidth      = 8;
   localparam int unsigned DepthWidth    = 6;
   localparam int unsigned UnderWidth    = 16;
   localparam int unsigned WindowWidth   = 15;   // 320 * 63 fits in 15 bits
   localparam int unsigned ReqDataWidth  = 72;   // 67 payload bits, padded to bytes
   localparam int unsigned RspDataWidth  = 32;   // 28 payload bits, padded to bytes

   localparam logic [DepthWidth-1:0] DepthReset = 6'd6;
   localparam logic [TsWidth-1:0]    TickStep   = 32'd80;
   localparam logic [UnderWidth-1:0] UnderMax   = 16'hFFFF;

   typedef enum logic [1:0] {
      REQ_PACKET = 2'd0,
      REQ_TICK   = 2'd1,
      REQ_REPORT = 2'd2,
      REQ_UNUSED = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      VERDICT_ACCEPT       = 3'd0,
      VERDICT_NOT_DUE      = 3'd1,
      VERDICT_OUT_OF_ORDER = 3'd2,
      VERDICT_REANCHOR     = 3'd3,
      VERDICT_NON_PACKET   = 3'd4
   } verdict_type;

   typedef struct packed {
      req_kind_type           kind;
      logic [AvgWidth-1:0]    avg_packets;
      logic [SizeWidth-1:0]   pkt_size;
      logic [SeqWidth-1:0]    pkt_seq;
      logic [TsWidth-1:0]     pkt_timestamp;
   } req_item_type;

   typedef struct packed {
      verdict_type            verdict;
      logic [UnderWidth-1:0]  underflows;
      logic                   drift_seen;
      logic [SizeWidth-1:0]   accepted_size;
   } rsp_item_type;

endpackage

`default_nettype wire

/* src/rpa_engine.sv */
// Admission state and the single-pass decision logic for one event.
// Depends on rpa_pkg.
`default_nettype none

module rpa_engine (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              fire,
   input  wire rpa_pkg::req_item_type             item,
   input  wire logic [rpa_pkg::DepthWidth-1:0]    wait_frames,
   output rpa_pkg::rsp_item_type                  result
);

   logic [rpa_pkg::TsWidth-1:0]    pull_count_ff, pull_count_in;
   logic [rpa_pkg::SeqWidth-1:0]   last_seq_ff, last_seq_in;
   logic                           first_pending_ff, first_pending_in;
   logic                           drift_flag_ff, drift_flag_in;
   logic [rpa_pkg::UnderWidth-1:0] underflow_count_ff, underflow_count_in;
   logic [rpa_pkg::AvgWidth-1:0]   last_report_ff, last_report_in;
   logic                           report_valid_ff, report_valid_in;

   logic [rpa_pkg::WindowWidth-1:0] window;
   logic [rpa_pkg::WindowWidth-1:0] half_window;
   logic                            ts_after;
   logic [rpa_pkg::TsWidth-1:0]     delta;
   logic                            far;
   logic [rpa_pkg::SeqWidth-1:0]    seq_diff;
   logic [rpa_pkg::DepthWidth-1:0]  low_bound;
   logic [rpa_pkg::AvgWidth-1:0]    prev_report;

   // 320 * depth as two shifted copies; the short offset is half of it
   assign window      = (rpa_pkg::WindowWidth'(wait_frames) << 8)
                      + (rpa_pkg::WindowWidth'(wait_frames) << 6);
   assign half_window = window >> 1;

   assign ts_after = item.pkt_timestamp > pull_count_ff;
   assign delta    = ts_after ? (item.pkt_timestamp - pull_count_ff)
                              : (pull_count_ff - item.pkt_timestamp);
   assign far      = delta > rpa_pkg::TsWidth'(window);
   assign seq_diff = item.pkt_seq - last_seq_ff;

   assign low_bound   = (wait_frames > 6'd2) ? (wait_frames - 6'd1) : 6'd1;
   assign prev_report = report_valid_ff ? last_report_ff : item.avg_packets;

   always_comb begin
      pull_count_in      = pull_count_ff;
      last_seq_in        = last_seq_ff;
      first_pending_in   = first_pending_ff;
      drift_flag_in      = drift_flag_ff;
      underflow_count_in = underflow_count_ff;
      last_report_in     = last_report_ff;
      report_valid_in    = report_valid_ff;
      result.verdict       = rpa_pkg::VERDICT_NON_PACKET;
      result.accepted_size = '0;

      unique case (item.kind)
         rpa_pkg::REQ_PACKET: begin
            if (first_pending_ff) begin
               first_pending_in     = 1'b0;
               pull_count_in        = item.pkt_timestamp + rpa_pkg::TsWidth'(window);
               last_seq_in          = item.pkt_seq;
               result.verdict       = rpa_pkg::VERDICT_ACCEPT;
               result.accepted_size = item.pkt_size;
            end else if (far) begin
               pull_count_in  = item.pkt_timestamp
                              + (drift_flag_ff ? rpa_pkg::TsWidth'(window)
                                               : rpa_pkg::TsWidth'(half_window));
               result.verdict = rpa_pkg::VERDICT_REANCHOR;
            end else if (!ts_after) begin
               underflow_count_in = '0;
               if (seq_diff[rpa_pkg::SeqWidth-1]) begin
                  result.verdict = rpa_pkg::VERDICT_OUT_OF_ORDER;
               end else begin
                  last_seq_in          = item.pkt_seq;
                  result.verdict       = rpa_pkg::VERDICT_ACCEPT;
                  result.accepted_size = item.pkt_size;
               end
            end else begin
               if (underflow_count_ff != rpa_pkg::UnderMax) begin
                  underflow_count_in = underflow_count_ff + 16'd1;
               end
               result.verdict = rpa_pkg::VERDICT_NOT_DUE;
            end
         end
         rpa_pkg::REQ_TICK: begin
            pull_count_in = pull_count_ff + rpa_pkg::TickStep;
         end
         rpa_pkg::REQ_REPORT: begin
            // reports of zero or one packet carry no information
            if (item.avg_packets > 8'd1) begin
               report_valid_in = 1'b1;
               last_report_in  = item.avg_packets;
               if ((item.avg_packets < rpa_pkg::AvgWidth'(low_bound)) &&
                   ({1'b0, prev_report} <= ({1'b0, item.avg_packets} + 9'd1))) begin
                  drift_flag_in = 1'b1;
               end
            end
         end
         rpa_pkg::REQ_UNUSED: begin
         end
         default: begin
         end
      endcase

      result.drift_seen = drift_flag_in;
      result.underflows = underflow_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pull_count_ff      <= '0;
         last_seq_ff        <= '0;
         first_pending_ff   <= 1'b1;
         drift_flag_ff      <= 1'b0;
         underflow_count_ff <= '0;
         last_report_ff     <= '0;
         report_valid_ff    <= 1'b0;
      end else if (fire) begin
         pull_count_ff      <= pull_count_in;
         last_seq_ff        <= last_seq_in;
         first_pending_ff   <= first_pending_in;
         drift_flag_ff      <= drift_flag_in;
         underflow_count_ff <= underflow_count_in;
         last_report_ff     <= last_report_in;
         report_valid_ff    <= report_valid_in;
      end
   end

endmodule

`default_nettype wire

/* src/rtp_playout_admission.sv */
// Playout admission control: top level with input and result stages and the
// depth register. Depends on rpa_pkg and rpa_engine.
//
// Usage:
//   req_* carries one event per transaction: a packet arrival, a frame tick
//   or a buffer length report, selected by req_tuser. Every event yields
//   exactly one transaction on rsp_*, in order, with the verdict in
//   rsp_tuser and size, drift flag and underflow count in rsp_tdata.
//   csr_* writes the target depth in frames (wait_frames); write it only
//   while no event is in flight. csr_ready is always high.
// Timing:
//   An event taken on req_* is registered in the input stage, evaluated out
//   of it by the engine, and its result is registered in the output stage
//   that drives rsp_*. One event per cycle is sustained while rsp_tready is
//   high; the engine updates the playout counter and sequence state per event.
// Reset: clears both stages, sets the depth to 6 frames, marks the next
//   packet as the first one and clears counter, flags and history.
// Stall: when rsp_tready is low the result holds in the output stage; one
//   more event parks in the input stage, then req_tready drops.
`default_nettype none

module rtp_playout_admission (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // event channel
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [31:0] pkt_timestamp, [47:32] pkt_seq, [58:48] pkt_size,
   // [66:59] avg_packets, [71:67] zero
   input  wire logic [rpa_pkg::ReqDataWidth-1:0]    req_tdata,
   // [1:0] req_type
   input  wire logic [1:0]                          req_tuser,
   // result channel
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [10:0] accepted_size, [11] drift_seen, [27:12] underflows, [31:28] zero
   output logic [rpa_pkg::RspDataWidth-1:0]         rsp_tdata,
   // [2:0] verdict
   output logic [2:0]                               rsp_tuser,
   // configuration: wait_frames
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [rpa_pkg::DepthWidth-1:0]      csr_wdata
);

   logic                             in_valid_ff, in_valid_in;
   rpa_pkg::req_item_type            in_item_ff;
   logic                             out_valid_ff, out_valid_in;
   rpa_pkg::rsp_item_type            out_item_ff;
   logic [rpa_pkg::DepthWidth-1:0]   wait_frames_ff;
   rpa_pkg::rsp_item_type            result;
   rpa_pkg::req_item_type            req_item;
   logic                             advance;
   logic                             req_take;

   // unpack the event transaction
   assign req_item.kind          = rpa_pkg::req_kind_type'(req_tuser);
   assign req_item.pkt_timestamp = req_tdata[31:0];
   assign req_item.pkt_seq       = req_tdata[47:32];
   assign req_item.pkt_size      = req_tdata[58:48];
   assign req_item.avg_packets   = req_tdata[66:59];

   // move the held event on whenever the result stage is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   assign csr_ready = 1'b1;

   rpa_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .item        (in_item_ff),
      .wait_frames (wait_frames_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         wait_frames_ff <= rpa_pkg::DepthReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            wait_frames_ff <= csr_wdata;
         end
      end
   end

   // payload stages: load on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_item_ff.verdict;
   assign rsp_tdata  = {4'd0, out_item_ff.underflows, out_item_ff.drift_seen,
                        out_item_ff.accepted_size};

endmodule

`default_nettype wire

/* src/rpa_checker.sv */
// Port-level checks for rtp_playout_admission, bound to the top level.
// Depends on rpa_pkg.
`default_nettype none

module rpa_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tready,
   input  wire logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic [rpa_pkg::RspDataWidth-1:0]    rsp_tdata,
   input  wire logic [2:0]                          rsp_tuser
);

   logic drift_shown_ff;

   // remember a delivered drift flag; it is sticky until reset
   always_ff @(posedge clock) begin
      if (reset) begin
         drift_shown_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready && rsp_tdata[11]) begin
         drift_shown_ff <= 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_drift_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && drift_shown_ff |-> rsp_tdata[11])
      else $error("drift flag cleared without reset");

   a_not_due_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == rpa_pkg::VERDICT_NOT_DUE) |-> rsp_tdata[27:12] != 16'd0)
      else $error("not-due verdict with zero underflow count");

   a_size_only_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != rpa_pkg::VERDICT_ACCEPT) |-> rsp_tdata[10:0] == 11'd0)
      else $error("size reported on a verdict other than accept");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("event channel stalled with empty result stage");

endmodule

bind rtp_playout_admission rpa_checker u_rpa_checker (.*);

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for rtp_playout_admission: directed and random event streams,
// a transaction-level predictor of verdicts and counters, and a stalling result sink.
// Depends on rpa_pkg and the rtp_playout_admission RTL.
`default_nettype none

module testbench;

   localparam int unsigned CycleLimit   = 1_500_000;
   localparam int unsigned RunItems     = 16;
   localparam int unsigned MaxPrinted   = 20;
   localparam logic [31:0] FrameSamples = 32'd80;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [5:0]  csr_wdata  = '0;

   rtp_playout_admission dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Predictor state, updated once per accepted transaction.
   logic [5:0]  depth_frames      = rpa_pkg::DepthReset;
   logic [31:0] playout_time      = '0;
   logic [15:0] newest_seq        = '0;
   logic        first_packet_due  = 1'b1;
   logic        drift_sticky      = 1'b0;
   logic [15:0] underflow_run     = '0;
   logic [7:0]  prev_avg          = '0;
   logic        avg_seen          = 1'b0;

   rpa_pkg::rsp_item_type verdict_queue[$];

   int unsigned cycle_count     = 0;
   int unsigned mismatch_count  = 0;
   int unsigned results_checked = 0;
   int unsigned kind_count[4]   = '{default: 0};
   int unsigned verdict_count[5] = '{default: 0};
   int unsigned burst_left      = 0;
   bit          sender_gaps     = 1'b1;

   // Work out the result of one event and advance the predictor state.
   function automatic rpa_pkg::rsp_item_type admit_event(input rpa_pkg::req_kind_type kind,
                                                         input logic [31:0] ts,
                                                         input logic [15:0] seq,
                                                         input logic [10:0] size,
                                                         input logic [7:0] avg);
      rpa_pkg::rsp_item_type r;
      logic [31:0]  window;
      logic [31:0]  distance;
      logic [15:0]  seq_age;
      logic [7:0]   short_bound;
      r.verdict       = rpa_pkg::VERDICT_NON_PACKET;
      r.accepted_size = '0;
      window          = 32'(320 * depth_frames);
      case (kind)
         rpa_pkg::REQ_PACKET: begin
            if (first_packet_due) begin
               first_packet_due = 1'b0;
               playout_time     = ts + window;
               newest_seq       = seq;
               r.verdict        = rpa_pkg::VERDICT_ACCEPT;
               r.accepted_size  = size;
            end else begin
               distance = (ts > playout_time) ? ts - playout_time : playout_time - ts;
               if (distance > window) begin
                  // Re-anchor: the offset is the full window once drift has been seen.
                  playout_time = ts + (drift_sticky ? window : 32'(160 * depth_frames));
                  r.verdict    = rpa_pkg::VERDICT_REANCHOR;
               end else if (ts <= playout_time) begin
                  underflow_run = '0;
                  seq_age       = seq - newest_seq;
                  if (seq_age[15]) begin
                     r.verdict = rpa_pkg::VERDICT_OUT_OF_ORDER;
                  end else begin
                     newest_seq      = seq;
                     r.verdict       = rpa_pkg::VERDICT_ACCEPT;
                     r.accepted_size = size;
                  end
               end else begin
                  if (underflow_run != 16'hFFFF) underflow_run++;
                  r.verdict = rpa_pkg::VERDICT_NOT_DUE;
               end
            end
         end
         rpa_pkg::REQ_TICK: begin
            playout_time = playout_time + FrameSamples;
         end
         rpa_pkg::REQ_REPORT: begin
            if (avg > 8'd1) begin
               short_bound = (depth_frames > 6'd2) ? 8'(depth_frames - 6'd1) : 8'd1;
               if (!avg_seen) begin
                  prev_avg = avg;
                  avg_seen = 1'b1;
               end
               // A rise or a drop of at most one packet while short counts as drift.
               if (avg < short_bound && {1'b0, prev_avg} <= {1'b0, avg} + 9'd1)
                  drift_sticky = 1'b1;
               prev_avg = avg;
            end
         end
         default: ;
      endcase
      r.drift_seen = drift_sticky;
      r.underflows = underflow_run;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= MaxPrinted)
         $display("mismatch in %s: expected 0x%0h, got 0x%0h (cycle %0d)",
                  what, want, got, cycle_count);
   endtask

   // Send one event; with sender_gaps set the sender runs in bursts with random idle gaps between them.
   task automatic send_event(input rpa_pkg::req_kind_type kind, input logic [31:0] ts,
                             input logic [15:0] seq, input logic [10:0] size,
                             input logic [7:0] avg);
      int unsigned gap;
      @(negedge clock);
      if (sender_gaps && burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'b0, avg, size, seq, ts};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      verdict_queue.push_back(admit_event(kind, ts, seq, size, avg));
      kind_count[kind]++;
   endtask

   // Hold the sender until every pending result has come back.
   task automatic drain_results;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (verdict_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_depth(input logic [5:0] frames);
      drain_results();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= frames;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      depth_frames = frames;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_packet(input logic [31:0] ts, input logic [15:0] seq,
                              input logic [10:0] size);
      send_event(rpa_pkg::REQ_PACKET, ts, seq, size, 8'($urandom));
   endtask

   task automatic send_report(input logic [7:0] avg);
      send_event(rpa_pkg::REQ_REPORT, $urandom, 16'($urandom), 11'($urandom), avg);
   endtask

   // Events before any packet: nothing but the counter may move.
   task automatic test_idle_events;
      send_event(rpa_pkg::REQ_TICK, '0, '0, '0, '0);
      send_event(rpa_pkg::REQ_UNUSED, '1, '1, '1, '1);
      send_report(8'd0);
      send_report(8'd1);
   endtask

   task automatic test_first_packet;
      send_packet(32'hFFFF_F000, 16'hFFFF, 11'd2047);
   endtask

   // Walk every packet verdict and the window and sequence-age boundaries.
   task automatic test_packet_verdicts;
      send_packet(playout_time, 16'h0000, 11'd0);
      send_packet(playout_time - 32'(320 * depth_frames), 16'h7FFF, 11'd1234);
      send_packet(playout_time, 16'hFFFF, 11'd77);                       // age of half the range
      send_packet(playout_time - 32'd5, 16'h7FFF, 11'd5);                // same sequence number
      send_packet(playout_time + 32'd1, 16'h8000, 11'd9);
      send_packet(playout_time + 32'(320 * depth_frames), 16'h8000, 11'd9);
      send_event(rpa_pkg::REQ_TICK, '1, '1, '1, '1);
      send_packet(playout_time, 16'h8000, 11'd2047);                      // due again, clears run
      send_packet(playout_time + 32'd40, 16'h8001, 11'd3);
      send_packet(playout_time + 32'(320 * depth_frames) + 32'd1, 16'h8001, 11'd3);
      send_packet(playout_time - 32'(320 * depth_frames) - 32'd1, 16'h8001, 11'd3);
      send_packet(playout_time ^ 32'h8000_0000, 16'h8002, 11'd3);
      send_packet(32'hFFFF_FFF0, 16'h8003, 11'd3);                        // offset wraps the counter
      send_event(rpa_pkg::REQ_TICK, '0, '0, '0, '0);
   endtask

   // Mixed random events; without reports only the ignored small ones are sent.
   task automatic run_random(input int unsigned count, input bit with_reports);
      int unsigned pick;
      int          span;
      int          off;
      logic [31:0] window;
      logic [31:0] ts;
      logic [15:0] seq;
      logic [10:0] size;
      logic [7:0]  avg;
      for (int unsigned n = 0; n < count; n++) begin
         if (n % 40 == 0) sender_gaps = ($urandom_range(0, 3) != 0);
         window = 32'(320 * depth_frames);
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
               off = int'($urandom_range(0, 2 * window)) - int'(window);
               ts  = playout_time + 32'(off);
            end
            11, 12, 13: begin
               case ($urandom_range(0, 3))
                  0: ts = playout_time - window;
                  1: ts = playout_time + window;
                  2: ts = playout_time - window - 32'd1;
                  default: ts = playout_time + window + 32'd1;
               endcase
            end
            14, 15, 16: begin
               span = int'(window + window / 2 + 2);
               off  = int'($urandom_range(0, 2 * span)) - span;
               ts   = playout_time + 32'(off);
            end
            default: ts = $urandom;
         endcase
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13:
               seq = newest_seq + 16'($urandom_range(0, 3));
            14, 15, 16: seq = newest_seq - 16'($urandom_range(1, 4));
            default: seq = 16'($urandom);
         endcase
         if ($urandom_range(0, 9) == 0)
            size = $urandom_range(0, 1) ? 11'd2047 : 11'd0;
         else
            size = 11'($urandom);
         if (!with_reports)
            avg = 8'($urandom_range(0, 1));
         else if ($urandom_range(0, 1) == 1)
            avg = 8'($urandom_range(0, 64));
         else
            avg = 8'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 65)
            send_event(rpa_pkg::REQ_PACKET, ts, seq, size, avg);
         else if (pick < 85)
            send_event(rpa_pkg::REQ_TICK, ts, seq, size, avg);
         else if (pick < 95)
            send_event(rpa_pkg::REQ_REPORT, ts, seq, size, avg);
         else
            send_event(rpa_pkg::REQ_UNUSED, $urandom, 16'($urandom), 11'($urandom),
                       8'($urandom));
      end
      sender_gaps = 1'b1;
   endtask

   task automatic test_random_steady;
      run_random(150, 1'b0);
      write_depth(6'($urandom_range(2, 62)));
      run_random(120, 1'b0);
      write_depth(6'd63);
      run_random(80, 1'b0);
      write_depth(6'd1);
      run_random(60, 1'b0);
      write_depth(rpa_pkg::DepthReset);
   endtask

   // The first valid report is short and flat, so drift latches at once.
   task automatic test_drift_detect;
      send_report(8'd3);
      send_packet(playout_time + 32'(320 * depth_frames) + 32'd1, newest_seq, 11'd10);
      send_report(8'd255);
      send_report(8'd4);
      send_report(8'd5);
      send_report(8'd2);
   endtask

   // Zero depth: only an exact match is due, anything else re-anchors onto itself.
   task automatic test_depth_extremes;
      write_depth(6'd0);
      send_packet(playout_time + 32'd7, newest_seq + 16'd1, 11'd21);
      send_packet(playout_time, newest_seq + 16'd1, 11'd22);
      send_packet(playout_time - 32'd1, newest_seq + 16'd1, 11'd23);
      send_report(8'd2);
      write_depth(6'd1);
      send_packet(playout_time + 32'd320, newest_seq, 11'd24);
      send_packet(playout_time + 32'd321, newest_seq, 11'd25);
      send_report(8'd2);
      write_depth(6'd63);
      send_packet(playout_time - 32'd20160, newest_seq + 16'd1, 11'd26);
      send_report(8'd61);
   endtask

   // A back-to-back run of not-due packets, then a due one that clears the run.
   task automatic test_underflow_run;
      write_depth(6'd63);
      sender_gaps = 1'b0;
      for (int unsigned n = 0; n < RunItems; n++)
         send_packet(playout_time + 32'($urandom_range(1, 20160)), 16'($urandom),
                     11'($urandom));
      send_packet(playout_time, newest_seq + 16'd1, 11'd100);
      sender_gaps = 1'b1;
      drain_results();
   endtask

   task automatic test_random_mixed;
      write_depth(6'($urandom_range(2, 62)));
      run_random(200, 1'b1);
      write_depth(6'd63);
      run_random(150, 1'b1);
      write_depth(6'd1);
      run_random(100, 1'b1);
      write_depth(6'd0);
      run_random(50, 1'b1);
      write_depth(6'($urandom_range(1, 63)));
      run_random(200, 1'b1);
   endtask

   // Result sink: a repeating random ready pattern; one draw in four has no stalls at all.
   int unsigned  sink_phase    = 0;
   logic [15:0]  ready_pattern = 16'hFFFF;
   always @(negedge clock) begin
      if (sink_phase % 64 == 0)
         ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1111);
      rsp_tready <= ready_pattern[sink_phase % 16];
      sink_phase++;
   end

   // Compare each result transaction against the oldest prediction.
   always @(posedge clock) begin : check_results
      rpa_pkg::rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_queue.size() == 0) begin
            report_mismatch("unexpected result", 32'd0, {rsp_tdata[28:0], rsp_tuser});
         end else begin
            want = verdict_queue.pop_front();
            results_checked++;
            verdict_count[want.verdict]++;
            if (rsp_tuser !== want.verdict)
               report_mismatch("verdict", 32'(want.verdict), 32'(rsp_tuser));
            if (rsp_tdata[10:0] !== want.accepted_size)
               report_mismatch("accepted_size", 32'(want.accepted_size), 32'(rsp_tdata[10:0]));
            if (rsp_tdata[11] !== want.drift_seen)
               report_mismatch("drift_seen", 32'(want.drift_seen), 32'(rsp_tdata[11]));
            if (rsp_tdata[27:12] !== want.underflows)
               report_mismatch("underflows", 32'(want.underflows), 32'(rsp_tdata[27:12]));
            if (rsp_tdata[31:28] !== 4'd0)
               report_mismatch("tdata padding", 32'd0, 32'(rsp_tdata[31:28]));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles with %0d results pending",
                  cycle_count, verdict_queue.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_idle_events();
      test_first_packet();
      test_packet_verdicts();
      test_random_steady();
      test_drift_detect();
      test_depth_extremes();
      test_underflow_run();
      test_random_mixed();
      drain_results();
      repeat (10) @(posedge clock);
      $display("Sent %0d packets, %0d ticks, %0d reports, %0d unused events; checked %0d results.",
               kind_count[rpa_pkg::REQ_PACKET], kind_count[rpa_pkg::REQ_TICK],
               kind_count[rpa_pkg::REQ_REPORT], kind_count[rpa_pkg::REQ_UNUSED],
               results_checked);
      $display("Verdicts: %0d accepted, %0d not due, %0d out of order, %0d re-anchored; %0d %s",
               verdict_count[rpa_pkg::VERDICT_ACCEPT], verdict_count[rpa_pkg::VERDICT_NOT_DUE],
               verdict_count[rpa_pkg::VERDICT_OUT_OF_ORDER],
               verdict_count[rpa_pkg::VERDICT_REANCHOR], mismatch_count, "mismatches.");
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
src/rpa_pkg.sv
src/rpa_engine.sv
src/rtp_playout_admission.sv
src/rpa_checker.sv
dv/testbench.sv
